// ----- src/qrpmm_pkg.sv -----
// Shared types, register indexes and mixer constants for the rate PID motor mixer.
package qrpmm_pkg;

   localparam int GAIN_W  = 16;
   localparam int IN_W    = 16;
   localparam int ERR_W   = 15;
   localparam int DIFF_W  = 16;
   localparam int SUM_W   = 32;
   localparam int PP_W    = 32;
   localparam int PI_W    = 49;
   localparam int PD_W    = 33;
   localparam int DRIVE_W = 42;
   localparam int MIX_W   = 45;
   localparam int MOTOR_W = 31;
   localparam int CSR_IDX_W = 3;

   localparam int ERR_LIMIT    = 10000;
   localparam logic [GAIN_W-1:0] RESET_P_GAIN = 16'h0100;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENABLE,
      REG_YAW_P,
      REG_YAW_I,
      REG_YAW_D,
      REG_TILT_P,
      REG_TILT_I,
      REG_TILT_D
   } qrpmm_reg_type;

   // Stage load strobes from the top-level pipeline control to each lane.
   typedef struct packed {
      logic load_err;
      logic load_pass;
      logic load_state;
      logic load_prod;
      logic load_drive;
   } qrpmm_adv_type;

   typedef logic signed [DRIVE_W-1:0] qrpmm_drive_type;
   typedef logic [MOTOR_W-1:0]        qrpmm_motor_type;

   // Per motor row: bit j set means drive j (yaw, pitch, roll, throttle) enters negated.
   localparam logic [3:0] MIX_NEG [4] = '{4'b0111, 4'b0001, 4'b0010, 4'b0100};

endpackage

// ----- src/qrpmm_lane.sv -----
// One axis PID lane: error clamp, state update, gain products and drive sum.
module qrpmm_lane (
   input  logic                                    clock,
   input  logic                                    reset,
   input  qrpmm_pkg::qrpmm_adv_type                adv,
   input  logic signed [qrpmm_pkg::IN_W-1:0]       set_val,
   input  logic signed [qrpmm_pkg::IN_W-1:0]       meas_val,
   input  logic [qrpmm_pkg::GAIN_W-1:0]            kp,
   input  logic [qrpmm_pkg::GAIN_W-1:0]            ki,
   input  logic [qrpmm_pkg::GAIN_W-1:0]            kd,
   output qrpmm_pkg::qrpmm_drive_type              drive
);
   import qrpmm_pkg::*;

   logic signed [IN_W:0]       raw_err;
   logic signed [ERR_W-1:0]    err_in, err_ff;
   logic signed [ERR_W-1:0]    last_err_ff;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SUM_W:0]      sum_wide;
   logic signed [DIFF_W-1:0]   diff_in;
   logic signed [ERR_W-1:0]    p_err_ff;
   logic signed [DIFF_W-1:0]   diff_ff;
   logic signed [SUM_W-1:0]    isum_ff;
   logic signed [PP_W-1:0]     pp_ff;
   logic signed [PI_W-1:0]     pi_ff;
   logic signed [PD_W-1:0]     pd_ff;
   qrpmm_drive_type            drive_ff, drive_in;

   always_comb begin
      raw_err = (IN_W+1)'(set_val) - (IN_W+1)'(meas_val);
      if (raw_err > (IN_W+1)'(ERR_LIMIT)) begin
         err_in = ERR_W'(ERR_LIMIT);
      end else if (raw_err < -(IN_W+1)'(ERR_LIMIT)) begin
         err_in = -ERR_W'(ERR_LIMIT);
      end else begin
         err_in = raw_err[ERR_W-1:0];
      end
   end

   always_comb begin
      diff_in  = DIFF_W'(err_ff) - DIFF_W'(last_err_ff);
      sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(err_ff);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      drive_in = DRIVE_W'(pp_ff >>> 8) + DRIVE_W'(pi_ff >>> 8) + DRIVE_W'(pd_ff >>> 8);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
         sum_ff      <= '0;
      end else if (adv.load_state) begin
         last_err_ff <= err_ff;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.load_err) begin
         err_ff <= err_in;
      end
      if (adv.load_pass) begin
         p_err_ff <= err_ff;
         diff_ff  <= diff_in;
         isum_ff  <= sum_in;
      end
      if (adv.load_prod) begin
         pp_ff <= PP_W'($signed({1'b0, kp}) * p_err_ff);
         pi_ff <= PI_W'($signed({1'b0, ki}) * isum_ff);
         pd_ff <= PD_W'($signed({1'b0, kd}) * diff_ff);
      end
      if (adv.load_drive) begin
         drive_ff <= drive_in;
      end
   end

   assign drive = drive_ff;

   a_last_err_bound: assert property (@(posedge clock) disable iff (reset)
      (last_err_ff <= ERR_W'(ERR_LIMIT)) && (last_err_ff >= -ERR_W'(ERR_LIMIT)))
      else $error("last error outside clamp range");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !adv.load_state |=> $stable(sum_ff) && $stable(last_err_ff))
      else $error("axis state changed without an item");

endmodule

// ----- src/qrpmm_mixer.sv -----
// X-quad mixer: signed sum of quarter drives per motor with output clamp.
module qrpmm_mixer (
   input  qrpmm_pkg::qrpmm_drive_type  drive_in [4],
   output qrpmm_pkg::qrpmm_motor_type  motor [4]
);
   import qrpmm_pkg::*;

   logic signed [DRIVE_W:0]  term;
   logic signed [MIX_W-1:0]  acc;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         acc = '0;
         for (int j = 0; j < 4; j++) begin
            term = MIX_NEG[i][j] ? -(DRIVE_W+1)'(drive_in[j]) : (DRIVE_W+1)'(drive_in[j]);
            acc  = acc + MIX_W'(term >>> 2);
         end
         if (acc < 0) begin
            motor[i] = '0;
         end else if (acc[MIX_W-1:MOTOR_W] != '0) begin
            motor[i] = '1;
         end else begin
            motor[i] = acc[MOTOR_W-1:0];
         end
      end
   end

endmodule

// ----- src/quad_rate_pid_motor_mixer.sv -----
// Top level: rate PID over three axis lanes feeding the X-quad motor mixer.
// A beat passes the error, pass, product, drive and output registers in turn.
// Throughput: one beat per cycle; the pipeline stalls from the output register back.
// Per-axis error and integral state update per beat, so beats follow back to back.
// Reset: synchronous; controller disabled, P gains 0x0100, other gains and state zero.
module quad_rate_pid_motor_mixer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [qrpmm_pkg::IN_W-1:0]     req_set_yaw,
   input  logic signed [qrpmm_pkg::IN_W-1:0]     req_set_pitch,
   input  logic signed [qrpmm_pkg::IN_W-1:0]     req_set_roll,
   input  logic signed [qrpmm_pkg::IN_W-1:0]     req_set_throttle,
   input  logic signed [qrpmm_pkg::IN_W-1:0]     req_rate_yaw,
   input  logic signed [qrpmm_pkg::IN_W-1:0]     req_rate_pitch,
   input  logic signed [qrpmm_pkg::IN_W-1:0]     req_rate_roll,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [qrpmm_pkg::MOTOR_W-1:0]         rsp_motor_one,
   output logic [qrpmm_pkg::MOTOR_W-1:0]         rsp_motor_two,
   output logic [qrpmm_pkg::MOTOR_W-1:0]         rsp_motor_three,
   output logic [qrpmm_pkg::MOTOR_W-1:0]         rsp_motor_four,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [qrpmm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [qrpmm_pkg::GAIN_W-1:0]          csr_data
);
   import qrpmm_pkg::*;

   logic                 enable_ff;
   logic [GAIN_W-1:0]    yaw_p_ff, yaw_i_ff, yaw_d_ff;
   logic [GAIN_W-1:0]    tilt_p_ff, tilt_i_ff, tilt_d_ff;

   logic [4:0]           v_ff;
   logic [4:0]           rdy;
   logic                 req_take;
   qrpmm_adv_type        adv;

   logic signed [IN_W-1:0] thr_ff [4];
   qrpmm_drive_type      drives [4];
   qrpmm_motor_type      mix_out [4];
   qrpmm_motor_type      motor_ff [4];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         yaw_p_ff  <= RESET_P_GAIN;
         yaw_i_ff  <= '0;
         yaw_d_ff  <= '0;
         tilt_p_ff <= RESET_P_GAIN;
         tilt_i_ff <= '0;
         tilt_d_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (qrpmm_reg_type'(csr_index))
            REG_ENABLE: enable_ff <= csr_data[0];
            REG_YAW_P:  yaw_p_ff  <= csr_data;
            REG_YAW_I:  yaw_i_ff  <= csr_data;
            REG_YAW_D:  yaw_d_ff  <= csr_data;
            REG_TILT_P: tilt_p_ff <= csr_data;
            REG_TILT_I: tilt_i_ff <= csr_data;
            REG_TILT_D: tilt_d_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rdy[4] = !v_ff[4] || !rsp_stall;
      for (int k = 3; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign req_stall = !rdy[0];
   assign req_take  = req_valid && rdy[0] && enable_ff;

   always_comb begin
      adv.load_err   = rdy[0];
      adv.load_pass  = rdy[1];
      adv.load_state = rdy[1] && v_ff[0];
      adv.load_prod  = rdy[2];
      adv.load_drive = rdy[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_take;
         end
         for (int k = 1; k < 5; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         thr_ff[0] <= req_set_throttle;
      end
      for (int k = 1; k < 4; k++) begin
         if (rdy[k]) begin
            thr_ff[k] <= thr_ff[k-1];
         end
      end
      if (rdy[4]) begin
         motor_ff <= mix_out;
      end
   end

   qrpmm_lane u_lane_yaw (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .set_val  (req_set_yaw),
      .meas_val (req_rate_yaw),
      .kp       (yaw_p_ff),
      .ki       (yaw_i_ff),
      .kd       (yaw_d_ff),
      .drive    (drives[0])
   );

   qrpmm_lane u_lane_pitch (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .set_val  (req_set_pitch),
      .meas_val (req_rate_pitch),
      .kp       (tilt_p_ff),
      .ki       (tilt_i_ff),
      .kd       (tilt_d_ff),
      .drive    (drives[1])
   );

   qrpmm_lane u_lane_roll (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .set_val  (req_set_roll),
      .meas_val (req_rate_roll),
      .kp       (tilt_p_ff),
      .ki       (tilt_i_ff),
      .kd       (tilt_d_ff),
      .drive    (drives[2])
   );

   assign drives[3] = DRIVE_W'(thr_ff[3]);

   qrpmm_mixer u_mixer (
      .drive_in (drives),
      .motor    (mix_out)
   );

   assign rsp_valid       = v_ff[4];
   assign rsp_motor_one   = motor_ff[0];
   assign rsp_motor_two   = motor_ff[1];
   assign rsp_motor_three = motor_ff[2];
   assign rsp_motor_four  = motor_ff[3];

   a_disabled_no_beat: assert property (@(posedge clock) disable iff (reset)
      (!enable_ff && rdy[0]) |=> !v_ff[0])
      else $error("beat entered pipeline while disabled");

   a_no_drop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (v_ff[4] && rsp_stall && v_ff[3]) |=> v_ff[3] && v_ff[4])
      else $error("pipeline lost a beat under stall");

   a_bubble_accepts: assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> !req_stall)
      else $error("input stalled with an empty first stage");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the rate PID motor mixer: directed, random and windup beats.
module testbench;
   import qrpmm_pkg::*;

   localparam int RUN_LIMIT    = 3_000_000;
   localparam int LATENCY      = 5;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_BEATS  = 140;
   localparam int WINDUP_BEATS = 40;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam longint ACC_MAX   = 64'sd2147483647;
   localparam longint ACC_MIN   = -64'sd2147483648;
   localparam int MIX_SIGN [4][4] = '{'{-1, -1, -1, 1}, '{-1, 1, 1, 1},
                                      '{1, -1, 1, 1}, '{1, 1, -1, 1}};

   typedef struct packed {
      logic [IN_W-1:0] set_yaw;
      logic [IN_W-1:0] set_pitch;
      logic [IN_W-1:0] set_roll;
      logic [IN_W-1:0] throttle;
      logic [IN_W-1:0] rate_yaw;
      logic [IN_W-1:0] rate_pitch;
      logic [IN_W-1:0] rate_roll;
   } rate_sample_type;

   typedef logic [3:0][MOTOR_W-1:0] motor_forces_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [IN_W-1:0] req_set_yaw, req_set_pitch, req_set_roll, req_set_throttle;
   logic signed [IN_W-1:0] req_rate_yaw, req_rate_pitch, req_rate_roll;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [MOTOR_W-1:0] rsp_motor_one, rsp_motor_two, rsp_motor_three, rsp_motor_four;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [GAIN_W-1:0] csr_data = '0;

   rate_sample_type  cur_sample = '0;
   rate_sample_type  sample_queue [$];
   motor_forces_type expected_forces [$];

   int fail_count    = 0;
   int cycle_count   = 0;
   bit beat_taken    = 1'b0;
   int tx_gap        = 0;
   int rx_stall_left = 0;
   int hold_left     = 0;
   bit tx_idle_on    = 1'b0;
   bit rx_idle_on    = 1'b0;

   // controller model state; index 0 yaw gains, 1 tilt gains
   logic              ctl_enable = 1'b0;
   logic [GAIN_W-1:0] p_gain [2] = '{RESET_P_GAIN, RESET_P_GAIN};
   logic [GAIN_W-1:0] i_gain [2] = '{16'd0, 16'd0};
   logic [GAIN_W-1:0] d_gain [2] = '{16'd0, 16'd0};
   int                prev_err [3] = '{0, 0, 0};
   int                err_acc  [3] = '{0, 0, 0};

   assign req_set_yaw      = cur_sample.set_yaw;
   assign req_set_pitch    = cur_sample.set_pitch;
   assign req_set_roll     = cur_sample.set_roll;
   assign req_set_throttle = cur_sample.throttle;
   assign req_rate_yaw     = cur_sample.rate_yaw;
   assign req_rate_pitch   = cur_sample.rate_pitch;
   assign req_rate_roll    = cur_sample.rate_roll;

   quad_rate_pid_motor_mixer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_set_yaw      (req_set_yaw),
      .req_set_pitch    (req_set_pitch),
      .req_set_roll     (req_set_roll),
      .req_set_throttle (req_set_throttle),
      .req_rate_yaw     (req_rate_yaw),
      .req_rate_pitch   (req_rate_pitch),
      .req_rate_roll    (req_rate_roll),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_motor_one    (rsp_motor_one),
      .rsp_motor_two    (rsp_motor_two),
      .rsp_motor_three  (rsp_motor_three),
      .rsp_motor_four   (rsp_motor_four),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      case (idx)
         REG_ENABLE: ctl_enable = val[0];
         REG_YAW_P:  p_gain[0] = val;
         REG_YAW_I:  i_gain[0] = val;
         REG_YAW_D:  d_gain[0] = val;
         REG_TILT_P: p_gain[1] = val;
         REG_TILT_I: i_gain[1] = val;
         REG_TILT_D: d_gain[1] = val;
         default: ;
      endcase
   endfunction

   function automatic longint pid_axis(int ax, int setp, int meas, int g);
      int     err;
      int     diff;
      longint acc;
      err = setp - meas;
      if (err > ERR_LIMIT) err = ERR_LIMIT;
      if (err < -ERR_LIMIT) err = -ERR_LIMIT;
      diff = err - prev_err[ax];
      prev_err[ax] = err;
      acc = longint'(err_acc[ax]) + err;
      if (acc > ACC_MAX) acc = ACC_MAX;
      if (acc < ACC_MIN) acc = ACC_MIN;
      err_acc[ax] = int'(acc);
      return ((longint'(p_gain[g]) * err) >>> 8)
           + ((longint'(i_gain[g]) * err_acc[ax]) >>> 8)
           + ((longint'(d_gain[g]) * diff) >>> 8);
   endfunction

   function automatic motor_forces_type predict_forces(rate_sample_type s);
      longint           drive [4];
      longint           f;
      motor_forces_type m;
      drive[0] = pid_axis(0, $signed(s.set_yaw), $signed(s.rate_yaw), 0);
      drive[1] = pid_axis(1, $signed(s.set_pitch), $signed(s.rate_pitch), 1);
      drive[2] = pid_axis(2, $signed(s.set_roll), $signed(s.rate_roll), 1);
      drive[3] = longint'($signed(s.throttle));
      for (int r = 0; r < 4; r++) begin
         f = 0;
         for (int j = 0; j < 4; j++) f += (MIX_SIGN[r][j] * drive[j]) >>> 2;
         if (f < 0) f = 0;
         if (f > ACC_MAX) f = ACC_MAX;
         m[r] = f[MOTOR_W-1:0];
      end
      return m;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return RESET_P_GAIN;
         4, 5, 6: return GAIN_W'($urandom_range(0, 1023));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   // measured rate that gives the wanted error against a setpoint, kept in range
   function automatic logic [IN_W-1:0] offset_rate(logic [IN_W-1:0] setp, int delta);
      int v;
      v = $signed(setp) - delta;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return IN_W'(v);
   endfunction

   function automatic int pick_error(int mode);
      case (mode)
         1: return int'($urandom_range(0, 6000)) - 3000;
         2: return ($urandom_range(0, 1) ? 1 : -1) * (9998 + int'($urandom_range(0, 4)));
         default: return int'($urandom_range(0, 400)) - 200;
      endcase
   endfunction

   function automatic rate_sample_type random_sample();
      rate_sample_type s;
      int              mode;
      s.set_yaw    = IN_W'($urandom);
      s.set_pitch  = IN_W'($urandom);
      s.set_roll   = IN_W'($urandom);
      s.throttle   = IN_W'($urandom);
      s.rate_yaw   = IN_W'($urandom);
      s.rate_pitch = IN_W'($urandom);
      s.rate_roll  = IN_W'($urandom);
      mode = $urandom_range(0, 3);
      if (mode == 3) begin
         s.set_yaw   = IN_W'(int'($urandom_range(0, 4000)) - 2000);
         s.set_pitch = IN_W'(int'($urandom_range(0, 4000)) - 2000);
         s.set_roll  = IN_W'(int'($urandom_range(0, 4000)) - 2000);
         s.throttle  = IN_W'($urandom_range(0, 20000));
      end
      if (mode != 0) begin
         s.rate_yaw   = offset_rate(s.set_yaw, pick_error(mode));
         s.rate_pitch = offset_rate(s.set_pitch, pick_error(mode));
         s.rate_roll  = offset_rate(s.set_roll, pick_error(mode));
      end
      return s;
   endfunction

   // yaw and roll errors pinned at the positive limit, pitch at the negative one
   function automatic rate_sample_type windup_sample();
      rate_sample_type s;
      s = random_sample();
      s.set_yaw    = IN_W'($urandom_range(0, 32767));
      s.rate_yaw   = offset_rate(s.set_yaw, 10000 + int'($urandom_range(0, 22767)));
      s.set_roll   = IN_W'($urandom_range(0, 32767));
      s.rate_roll  = offset_rate(s.set_roll, 10000 + int'($urandom_range(0, 22767)));
      s.set_pitch  = IN_W'(-int'($urandom_range(0, 32767)));
      s.rate_pitch = offset_rate(s.set_pitch, -10000 - int'($urandom_range(0, 22767)));
      return s;
   endfunction

   function automatic rate_sample_type make_sample(int sy, int sp, int sr, int th,
                                                   int ry, int rp, int rr);
      rate_sample_type s;
      s.set_yaw    = IN_W'(sy);
      s.set_pitch  = IN_W'(sp);
      s.set_roll   = IN_W'(sr);
      s.throttle   = IN_W'(th);
      s.rate_yaw   = IN_W'(ry);
      s.rate_pitch = IN_W'(rp);
      s.rate_roll  = IN_W'(rr);
      return s;
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_gains(logic [GAIN_W-1:0] yp, logic [GAIN_W-1:0] yi,
                              logic [GAIN_W-1:0] yd, logic [GAIN_W-1:0] tp,
                              logic [GAIN_W-1:0] ti, logic [GAIN_W-1:0] td);
      csr_write(REG_YAW_P, yp);
      csr_write(REG_YAW_I, yi);
      csr_write(REG_YAW_D, yd);
      csr_write(REG_TILT_P, tp);
      csr_write(REG_TILT_I, ti);
      csr_write(REG_TILT_D, td);
   endtask

   // idle means no beat queued or offered and no result outstanding, plus pipeline flush
   task automatic drain();
      while (sample_queue.size() != 0 || req_valid || expected_forces.size() != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (tx_gap > 0) begin
            req_valid <= 1'b0;
            tx_gap--;
         end else if (sample_queue.size() > 0) begin
            cur_sample <= sample_queue.pop_front();
            req_valid  <= 1'b1;
            if (tx_idle_on) tx_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (rx_stall_left > 0) begin
         rsp_stall <= 1'b1;
         rx_stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (rx_idle_on) rx_stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      motor_forces_type want;
      motor_forces_type got;
      cycle_count++;
      beat_taken = !reset && req_valid && !req_stall;
      if (cycle_count > RUN_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_data);
         if (beat_taken && ctl_enable) expected_forces.push_back(predict_forces(cur_sample));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_motor_four, rsp_motor_three, rsp_motor_two, rsp_motor_one};
            if (expected_forces.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("cycle %0d: result beat with none expected", cycle_count);
            end else begin
               want = expected_forces.pop_front();
               for (int k = 0; k < 4; k++) begin
                  if (got[k] !== want[k]) begin
                     fail_count++;
                     if (fail_count <= MAX_REPORTS)
                        $display("cycle %0d: motor %0d expected %0d actual %0d",
                                 cycle_count, k + 1, want[k], got[k]);
                  end
               end
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset: beats are swallowed
      repeat (4) sample_queue.push_back(random_sample());
      drain();
      csr_write(REG_UNMAPPED, '1);
      csr_write(REG_ENABLE, 16'd1);

      sample_queue.push_back(make_sample(0, 0, 0, 0, 0, 0, 0));
      sample_queue.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767));
      sample_queue.push_back(make_sample(-32768, -32768, -32768, -32768,
                                         -32768, -32768, -32768));
      sample_queue.push_back(make_sample(32767, 32767, 32767, 32767, -32768, -32768, -32768));
      sample_queue.push_back(make_sample(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
      sample_queue.push_back(make_sample(10000, -10000, 10001, 1000, 0, 0, 0));
      sample_queue.push_back(make_sample(-10001, 9999, -9999, 2000, 0, 0, 0));
      sample_queue.push_back(make_sample(0, 0, 0, 32767, 0, 0, 0));
      sample_queue.push_back(make_sample(0, 0, 0, -32768, 0, 0, 0));
      sample_queue.push_back(make_sample(100, -200, 300, 4000, -100, 200, -300));
      drain();
      write_gains('1, '1, '1, '1, '1, '1);
      sample_queue.push_back(make_sample(32767, 32767, 32767, 32767, -32768, -32768, -32768));
      sample_queue.push_back(make_sample(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
      sample_queue.push_back(make_sample(32767, 32767, 32767, 0, -32768, -32768, -32768));
      sample_queue.push_back(make_sample(0, 0, 0, 32767, 0, 0, 0));
      sample_queue.push_back(make_sample(-5000, 5000, 1, 0, 5000, -5000, 0));
      sample_queue.push_back(make_sample(0, 0, 0, 0, 0, 0, 0));
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 0) write_gains('0, '0, '0, '0, '0, '0);
         else if (ph == 1) write_gains('1, '1, '1, '1, '1, '1);
         else write_gains(pick_gain(), pick_gain(), pick_gain(),
                          pick_gain(), pick_gain(), pick_gain());
         csr_write(REG_ENABLE, (ph == 6) ? 16'd0 : 16'd1);
         tx_idle_on = (ph % 3 != 2);
         rx_idle_on = (ph % 4 != 1);
         if (ph == 3) begin
            // receiver holds off while the sender keeps offering
            tx_idle_on = 1'b0;
            hold_left  = 300;
         end
         repeat ((ph == 6) ? 30 : PHASE_BEATS) sample_queue.push_back(random_sample());
         drain();
      end

      // push the integrators hard at full rate
      csr_write(REG_ENABLE, 16'd1);
      write_gains(RESET_P_GAIN, 16'd1, pick_gain(), RESET_P_GAIN, 16'd1, pick_gain());
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      repeat (WINDUP_BEATS) sample_queue.push_back(windup_sample());
      drain();

      write_gains('1, '1, '1, '1, '1, '1);
      repeat (3) sample_queue.push_back(windup_sample());
      sample_queue.push_back(make_sample(0, 0, 0, 0, 0, 0, 0));
      sample_queue.push_back(make_sample(-32768, 32767, -32768, 32767, 32767, -32768, 32767));
      sample_queue.push_back(make_sample(0, 0, 0, -32768, 0, 0, 0));
      drain();
      write_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain());
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      repeat (80) sample_queue.push_back(random_sample());
      drain();

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
